>>> hdl/stled_pkg.sv
`timescale 1ns / 1ps

package stled_pkg;

    // Digit store depth and derived widths
    localparam int MAX_DIGITS = 5;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam int FUNC_W   = 2;
    localparam int LEN_W    = 16;
    localparam int NUM_W    = 16;
    localparam int ELAPSE_W = 17;
    localparam int DIGIT_W  = 4;
    localparam int TICK_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int IN_DATA_W  = LEN_W + NUM_W;
    localparam int OUT_DATA_W = 8;

    localparam logic [ELAPSE_W-1:0] ELAPSED_MAX = '1;

    // Register reset values
    localparam logic [TICK_W-1:0] INTERVAL_RST = TICK_W'(400);
    localparam logic [TICK_W-1:0] GAP_RST      = TICK_W'(500);

    // Divide-by-ten of a 16-bit value: (n * 0xCCCD) >> 19 is exact
    localparam logic [NUM_W-1:0] DIV10_MUL   = 16'hCCCD;
    localparam int               DIV10_SHIFT = 19;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_FLASH  = 2'd1,
        FUNC_NUMBER = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOW = 2'd0,
        CFG_ENABLED    = 2'd1,
        CFG_INTERVAL   = 2'd2,
        CFG_GAP        = 2'd3
    } cfg_idx_t;

    // Digit blink phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ON   = 4'b0010,
        PH_OFF  = 4'b0100,
        PH_GAP  = 4'b1000
    } phase_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the accepted item, arm the decimal split
        logic conv_step;  // split off one decimal digit
        logic apply;      // update LED state and load the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic busy;       // a number sequence is running
        logic conv_done;  // decimal split finished
        logic out_free;   // result register can take a new result
    } dp_stat_t;

endpackage

>>> hdl/stled_ctrl.sv
`timescale 1ns / 1ps

module stled_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic [stled_pkg::FUNC_W-1:0]   s_tuser,
    output logic                           s_tready,
    input  stled_pkg::dp_stat_t            stat,
    output stled_pkg::dp_cmd_t             cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CONV  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && s_tready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.apply     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = accept;
                if (accept)
                begin
                    if (stled_pkg::func_t'(s_tuser) == stled_pkg::FUNC_NUMBER && !stat.busy)
                    begin
                        state_next = S_CONV;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_CONV:
            begin
                if (stat.conv_done)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    cmd.conv_step = 1'b1;
                end
            end
            S_APPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/stled_dp.sv
`timescale 1ns / 1ps

module stled_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stled_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stled_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [stled_pkg::FUNC_W-1:0]       s_tuser,
    input  logic [stled_pkg::IN_DATA_W-1:0]    s_tdata,
    input  stled_pkg::dp_cmd_t                 cmd,
    output stled_pkg::dp_stat_t                stat,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [stled_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int MD  = stled_pkg::MAX_DIGITS;
    localparam int CW  = stled_pkg::CNT_W;
    localparam int DW  = stled_pkg::DIGIT_W;
    localparam int TW  = stled_pkg::TICK_W;
    localparam int NW  = stled_pkg::NUM_W;
    localparam int EW  = stled_pkg::ELAPSE_W;
    localparam int LW  = stled_pkg::LEN_W;

    // Configuration registers
    logic          active_low_reg;
    logic          enabled_reg;
    logic [TW-1:0] interval_reg;
    logic [TW-1:0] gap_reg;

    // Latched item and decimal split
    stled_pkg::func_t func_reg;
    logic [LW-1:0]    flen_reg;
    logic [NW-1:0]    work_reg;
    logic [NW-1:0]    work_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic [DW-1:0]    store_reg [MD];
    logic [DW-1:0]    store_next [MD];

    // LED state
    logic                  lit_reg;
    logic                  lit_next;
    logic [LW-1:0]         half_reg;
    logic [LW-1:0]         half_next;
    logic [EW-1:0]         elapsed_reg;
    logic [EW-1:0]         elapsed_next;
    logic [CW-1:0]         left_reg;
    logic [CW-1:0]         left_next;
    logic [DW-1:0]         blinks_reg;
    logic [DW-1:0]         blinks_next;
    stled_pkg::phase_t     phase_reg;
    stled_pkg::phase_t     phase_next;
    logic [TW-1:0]         pticks_reg;
    logic [TW-1:0]         pticks_next;

    // Result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [stled_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [stled_pkg::OUT_DATA_W-1:0] out_data_next;

    // Divide by ten
    logic [2*NW-1:0] prod;
    logic [NW-1:0]   quot;
    logic [NW-1:0]   rem;

    // Helpers
    logic             busy;
    logic [TW-1:0]    limit;
    logic [TW:0]      pticks_inc;
    logic [DW-1:0]    blinks_dec;
    logic [DW-1:0]    shifted [MD];
    logic [EW-1:0]    elapsed_inc;

    assign busy = (phase_reg != stled_pkg::PH_IDLE);

    assign prod = work_reg * stled_pkg::DIV10_MUL;
    assign quot = NW'(prod >> stled_pkg::DIV10_SHIFT);
    assign rem  = work_reg - ((quot << 3) + (quot << 1));

    assign stat.busy      = busy;
    assign stat.conv_done = (work_reg == '0) || (cnt_reg == CW'(MD));
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg <= 1'b0;
            enabled_reg    <= 1'b1;
            interval_reg   <= stled_pkg::INTERVAL_RST;
            gap_reg        <= stled_pkg::GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (stled_pkg::cfg_idx_t'(cfg_index))
                stled_pkg::CFG_ACTIVE_LOW: active_low_reg <= cfg_data[0];
                stled_pkg::CFG_ENABLED:    enabled_reg    <= cfg_data[0];
                stled_pkg::CFG_INTERVAL:   interval_reg   <= cfg_data[TW-1:0];
                stled_pkg::CFG_GAP:        gap_reg        <= cfg_data[TW-1:0];
                default:                   ;
            endcase
        end
    end

    // Decimal split: one digit per cycle, digits shift in from the top
    always_comb
    begin
        work_next = work_reg;
        cnt_next  = cnt_reg;
        for (int i = 0; i < MD; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (cmd.load)
        begin
            work_next = s_tdata[LW +: NW];
            cnt_next  = '0;
        end
        else if (cmd.conv_step)
        begin
            work_next = quot;
            cnt_next  = cnt_reg + CW'(1);
            for (int i = 0; i < MD - 1; i++)
            begin
                store_next[i] = store_reg[i+1];
            end
            store_next[MD-1] = rem[DW-1:0];
        end
        else if (cmd.apply && func_reg == stled_pkg::FUNC_TICK && busy
                 && phase_reg == stled_pkg::PH_GAP
                 && pticks_inc >= {1'b0, limit} && left_reg > CW'(1))
        begin
            for (int i = 0; i < MD; i++)
            begin
                store_next[i] = shifted[i];
            end
        end
    end

    // Next digit moves up to the read position
    always_comb
    begin
        shifted[0] = '0;
        for (int i = 1; i < MD; i++)
        begin
            shifted[i] = store_reg[i-1];
        end
    end

    // Item payload and digit store
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= stled_pkg::func_t'(s_tuser);
            flen_reg <= s_tdata[LW-1:0];
        end
        work_reg <= work_next;
        cnt_reg  <= cnt_next;
        for (int i = 0; i < MD; i++)
        begin
            store_reg[i] <= store_next[i];
        end
    end

    // Phase limits and counters
    always_comb
    begin
        limit = (phase_reg == stled_pkg::PH_GAP) ? gap_reg : interval_reg;
        if (limit == '0)
        begin
            limit = TW'(1);
        end
        pticks_inc  = {1'b0, pticks_reg} + (TW+1)'(1);
        blinks_dec  = (blinks_reg != '0) ? blinks_reg - DW'(1) : '0;
        elapsed_inc = (elapsed_reg < stled_pkg::ELAPSED_MAX)
                      ? elapsed_reg + EW'(1) : elapsed_reg;
    end

    // LED and digit sequence update
    always_comb
    begin
        lit_next       = lit_reg;
        half_next      = half_reg;
        elapsed_next   = elapsed_reg;
        left_next      = left_reg;
        blinks_next    = blinks_reg;
        phase_next     = phase_reg;
        pticks_next    = pticks_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (cmd.apply)
        begin
            unique case (func_reg)
                stled_pkg::FUNC_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (busy)
                    begin
                        if (pticks_inc < {1'b0, limit})
                        begin
                            pticks_next = pticks_inc[TW-1:0];
                        end
                        else
                        begin
                            pticks_next = '0;
                            unique case (phase_reg)
                                stled_pkg::PH_ON:
                                begin
                                    lit_next   = 1'b0;
                                    phase_next = stled_pkg::PH_OFF;
                                end
                                stled_pkg::PH_OFF:
                                begin
                                    blinks_next = blinks_dec;
                                    if (blinks_dec != '0)
                                    begin
                                        lit_next   = 1'b1;
                                        phase_next = stled_pkg::PH_ON;
                                    end
                                    else
                                    begin
                                        phase_next = stled_pkg::PH_GAP;
                                    end
                                end
                                default:
                                begin
                                    // gap over: next digit or end of number
                                    lit_next = 1'b0;
                                    if (left_reg > CW'(1))
                                    begin
                                        left_next = left_reg - CW'(1);
                                        if (shifted[MD-1] != '0)
                                        begin
                                            blinks_next = shifted[MD-1];
                                            phase_next  = stled_pkg::PH_ON;
                                            lit_next    = 1'b1;
                                        end
                                        else
                                        begin
                                            blinks_next = '0;
                                            phase_next  = stled_pkg::PH_GAP;
                                        end
                                    end
                                    else
                                    begin
                                        left_next  = '0;
                                        phase_next = stled_pkg::PH_IDLE;
                                    end
                                end
                            endcase
                        end
                    end
                    else if (!enabled_reg || half_reg == '0)
                    begin
                        lit_next = 1'b0;
                    end
                    else if (elapsed_inc > {1'b0, half_reg})
                    begin
                        elapsed_next = '0;
                        lit_next     = !lit_reg;
                    end
                end
                stled_pkg::FUNC_FLASH:
                begin
                    if (!busy)
                    begin
                        lit_next     = 1'b1;
                        elapsed_next = '0;
                        half_next    = flen_reg;
                    end
                end
                stled_pkg::FUNC_NUMBER:
                begin
                    // most significant digit sits at the top of the store
                    if (!busy && cnt_reg != '0)
                    begin
                        left_next   = cnt_reg;
                        pticks_next = '0;
                        if (store_reg[MD-1] != '0)
                        begin
                            blinks_next = store_reg[MD-1];
                            phase_next  = stled_pkg::PH_ON;
                            lit_next    = 1'b1;
                        end
                        else
                        begin
                            blinks_next = '0;
                            phase_next  = stled_pkg::PH_GAP;
                            lit_next    = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            out_valid_next = 1'b1;
            out_data_next  = {5'b0, (phase_next != stled_pkg::PH_IDLE),
                              lit_next, lit_next ^ active_low_reg};
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg       <= 1'b0;
            half_reg      <= '0;
            elapsed_reg   <= '0;
            left_reg      <= '0;
            blinks_reg    <= '0;
            phase_reg     <= stled_pkg::PH_IDLE;
            pticks_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lit_reg       <= lit_next;
            half_reg      <= half_next;
            elapsed_reg   <= elapsed_next;
            left_reg      <= left_next;
            blinks_reg    <= blinks_next;
            phase_reg     <= phase_next;
            pticks_reg    <= pticks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

>>> hdl/status_led_flash_and_digit_blinker_unit.sv
`timescale 1ns / 1ps

// Channel  Signals                     Payload
// input    s_tvalid s_tready s_tdata   tdata: flash_length[15:0] number_value[31:16]
//                   s_tuser            tuser: func[1:0]
// output   m_tvalid m_tready m_tdata   tdata: pin_level[0] led_on[1] showing_digits[2]
// config   cfg_we cfg_index cfg_data   0 active_low, 1 enabled, 2 digit_interval, 3 gap_len
//
// One item at a time. Tick, flash and idle codes go from transfer to the update step,
// which loads the result register; a show-number item taken while no sequence runs first
// passes the decimal split, one digit per cycle; taken during a sequence it skips the split.
// Reset is asynchronous; no clearing pass is needed.
// The next item is taken while a result waits; a stalled output holds the block in its
// update step until the result register frees.

module status_led_flash_and_digit_blinker_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stled_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stled_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stled_pkg::IN_DATA_W-1:0]    s_tdata,   // flash_length, number_value
    input  logic [stled_pkg::FUNC_W-1:0]       s_tuser,   // func
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stled_pkg::OUT_DATA_W-1:0]   m_tdata    // pin_level, led_on, showing_digits
);

    stled_pkg::dp_cmd_t  cmd;
    stled_pkg::dp_stat_t stat;

    // Sequencer
    stled_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // LED state, digit split and result register
    stled_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hdl/stled_chk.sv
`timescale 1ns / 1ps

module stled_chk
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [stled_pkg::OUT_DATA_W-1:0]   m_tdata
);

    // One item in flight: input closes right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    // A new result follows an update step, not an idle cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in work");

    // Padding bits of the result stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:3] == 5'b0))
        else $error("result padding not zero");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind status_led_flash_and_digit_blinker_unit stled_chk u_stled_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb_status_led_flash_and_digit_blinker_unit.sv
`timescale 1ns / 1ps

module tb_status_led_flash_and_digit_blinker_unit;

    import stled_pkg::*;

    // One result transfer, packed as on m_tdata[2:0]
    typedef struct packed {
        logic show;
        logic led;
        logic pin;
    } led_out_t;

    // LED predictor plus store of expected results
    class led_scoreboard;
        logic                act_low;
        logic                en;
        logic [TICK_W-1:0]   interval;
        logic [TICK_W-1:0]   gap;
        logic                lit;
        logic [LEN_W-1:0]    half_period;
        logic [ELAPSE_W-1:0] elapsed;
        logic [DIGIT_W-1:0]  digits [MAX_DIGITS];
        logic [2:0]          n_digits;
        logic [2:0]          pos;
        logic [DIGIT_W-1:0]  blinks_left;
        phase_t              phase;
        logic [TICK_W-1:0]   ph_ticks;
        led_out_t            expected_q [$];
        int                  errors;

        function new();
            act_low     = 1'b0;
            en          = 1'b1;
            interval    = INTERVAL_RST;
            gap         = GAP_RST;
            lit         = 1'b0;
            half_period = '0;
            elapsed     = '0;
            foreach (digits[i]) digits[i] = '0;
            n_digits    = '0;
            pos         = '0;
            blinks_left = '0;
            phase       = PH_IDLE;
            ph_ticks    = '0;
            errors      = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_ACTIVE_LOW: act_low = v[0];
                CFG_ENABLED:    en = v[0];
                CFG_INTERVAL:   interval = v;
                CFG_GAP:        gap = v;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void start_digit();
            ph_ticks = '0;
            if (digits[pos] != 0)
            begin
                blinks_left = digits[pos];
                phase = PH_ON;
                lit = 1'b1;
            end
            else
            begin
                blinks_left = '0;
                phase = PH_GAP;
                lit = 1'b0;
            end
        endfunction

        // One tick of a running number sequence
        function void digit_tick();
            logic [TICK_W:0] lim;
            logic [TICK_W:0] t;
            lim = {1'b0, (phase == PH_GAP) ? gap : interval};
            if (lim == 0)
                lim = (TICK_W+1)'(1);
            t = {1'b0, ph_ticks} + (TICK_W+1)'(1);
            if (t < lim)
            begin
                ph_ticks = t[TICK_W-1:0];
                return;
            end
            ph_ticks = '0;
            case (phase)
                PH_ON:
                begin
                    lit = 1'b0;
                    phase = PH_OFF;
                end
                PH_OFF:
                begin
                    if (blinks_left > 0)
                        blinks_left--;
                    if (blinks_left > 0)
                    begin
                        lit = 1'b1;
                        phase = PH_ON;
                    end
                    else
                        phase = PH_GAP;
                end
                default:
                begin
                    lit = 1'b0;
                    pos++;
                    if (pos < n_digits)
                        start_digit();
                    else
                    begin
                        phase = PH_IDLE;
                        pos = '0;
                    end
                end
            endcase
        endfunction

        // Split into decimal digits, keeping only the low MAX_DIGITS of them
        function void load_number(logic [NUM_W-1:0] n);
            int                 cnt;
            int                 v;
            logic [DIGIT_W-1:0] rev [MAX_DIGITS];
            v = int'(n);
            cnt = 0;
            while (v > 0 && cnt < MAX_DIGITS)
            begin
                rev[cnt] = DIGIT_W'(v % 10);
                v = v / 10;
                cnt++;
            end
            if (cnt == 0)
                return;
            for (int i = 0; i < cnt; i++)
                digits[i] = rev[cnt - 1 - i];
            n_digits = 3'(cnt);
            pos = '0;
            start_digit();
        endfunction

        function void flash_tick();
            if (!en || half_period == 0)
            begin
                lit = 1'b0;
                return;
            end
            if (elapsed > half_period)
            begin
                elapsed = '0;
                lit = ~lit;
            end
        endfunction

        // Accepted input transfer: update the state, queue the result it causes
        function void note(func_t f, logic [LEN_W-1:0] len, logic [NUM_W-1:0] num);
            logic     busy;
            led_out_t r;
            busy = (phase != PH_IDLE);
            case (f)
                FUNC_TICK:
                begin
                    if (elapsed != ELAPSED_MAX)
                        elapsed++;
                    if (busy)
                        digit_tick();
                    else
                        flash_tick();
                end
                FUNC_FLASH:
                    if (!busy)
                    begin
                        lit = 1'b1;
                        elapsed = '0;
                        half_period = len;
                    end
                FUNC_NUMBER:
                    if (!busy)
                        load_number(num);
                default: ;
            endcase
            r.pin  = lit ^ act_low;
            r.led  = lit;
            r.show = (phase != PH_IDLE);
            expected_q.push_back(r);
        endfunction

        task report(string what, logic exp_v, logic got_v);
            if (errors < 40)
                $display("%0t mismatch %s: expected %b got %b", $time, what, exp_v, got_v);
            errors++;
        endtask

        // Accepted output transfer against the oldest expectation
        task check(logic [OUT_DATA_W-1:0] data);
            led_out_t e;
            led_out_t g;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", 1'b0, 1'b1);
                return;
            end
            e = expected_q.pop_front();
            g = data[2:0];
            if (g.pin !== e.pin)
                report("pin_level", e.pin, g.pin);
            if (g.led !== e.led)
                report("led_on", e.led, g.led);
            if (g.show !== e.show)
                report("showing_digits", e.show, g.show);
        endtask
    endclass

    // Per-phase register settings
    localparam logic              AL_TABLE  [8] = '{0, 1, 0, 1, 0, 1, 0, 1};
    localparam logic              EN_TABLE  [8] = '{1, 1, 0, 1, 1, 0, 1, 1};
    localparam logic [TICK_W-1:0] IV_TABLE  [8] = '{1, 2, 0, 3, 1023, 1, 2, 1};
    localparam logic [TICK_W-1:0] GAP_TABLE [8] = '{1, 3, 0, 1023, 2, 2, 1, 1};
    localparam int                PHASE_ITEMS = 230;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    led_scoreboard sb;
    int            idle_pct;
    int            stall_pct;
    int            hold_left;

    status_led_flash_and_digit_blinker_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata);
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("tb_status_led_flash_and_digit_blinker_unit: errors");
        $finish;
    end

    // One input transfer, entered and left at a falling edge
    task automatic send_item(func_t f, logic [LEN_W-1:0] len, logic [NUM_W-1:0] num);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {num, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note(f, len, num);
        @(negedge clk);
    endtask

    // Stop sending and wait for every expected result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Mostly ticks so that flashes and number sequences run to completion
    task automatic rand_item();
        int               r;
        func_t            f;
        logic [LEN_W-1:0] len;
        logic [NUM_W-1:0] num;
        r   = int'($urandom_range(99));
        len = LEN_W'($urandom());
        num = NUM_W'($urandom());
        if (r < 68)
            f = FUNC_TICK;
        else if (r < 78)
        begin
            f = FUNC_FLASH;
            if ($urandom_range(99) < 80)
                len = LEN_W'($urandom_range(7));
        end
        else if (r < 93)
        begin
            f = FUNC_NUMBER;
            r = int'($urandom_range(99));
            if (r < 10)
                num = '0;
            else if (r < 60)
                num = NUM_W'($urandom_range(1, 99));
            else if (r < 80)
                num = NUM_W'($urandom_range(100, 9999));
        end
        else
            f = FUNC_NONE;
        send_item(f, len, num);
    endtask

    initial
    begin
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset register values, flash toggling, unused code
        send_item(FUNC_TICK, '1, '1);
        send_item(FUNC_NONE, '1, '1);
        send_item(FUNC_FLASH, 16'd2, '0);
        repeat (4) send_item(FUNC_TICK, '0, '0);
        drain();
        cfg_write(CFG_ACTIVE_LOW, 10'd1);
        cfg_write(CFG_INTERVAL, 10'd1);
        cfg_write(CFG_GAP, 10'd1);

        // Directed: steady off, number zero, short numbers, busy commands, five digits
        send_item(FUNC_FLASH, '0, '0);
        send_item(FUNC_TICK, '0, '0);
        send_item(FUNC_NUMBER, '0, 16'd0);
        send_item(FUNC_NUMBER, '0, 16'd1);
        send_item(FUNC_TICK, '0, '0);
        send_item(FUNC_FLASH, 16'd5, '0);
        send_item(FUNC_NUMBER, '0, 16'd9);
        repeat (2) send_item(FUNC_TICK, '0, '0);
        send_item(FUNC_NUMBER, '0, 16'd10);
        repeat (4) send_item(FUNC_TICK, '0, '0);
        send_item(FUNC_NUMBER, '0, 16'hFFFF);
        send_item(FUNC_NONE, '0, '0);
        repeat (2) send_item(FUNC_TICK, '0, '0);

        // Random phases, each with its own registers and idling mode
        for (int p = 0; p < 8; p++)
        begin
            drain();
            cfg_write(CFG_ACTIVE_LOW, CFG_DATA_W'(AL_TABLE[p]));
            cfg_write(CFG_ENABLED, CFG_DATA_W'(EN_TABLE[p]));
            cfg_write(CFG_INTERVAL, IV_TABLE[p]);
            cfg_write(CFG_GAP, GAP_TABLE[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // receiver holds off while the sender keeps offering
                if (p == 1 && i == 100)
                    hold_left = 300;
                // sender pauses until the block has delivered everything
                if (p == 2 && i == 100)
                    drain();
                rand_item();
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (sb.errors == 0)
            $display("tb_status_led_flash_and_digit_blinker_unit: clean");
        else
            $display("tb_status_led_flash_and_digit_blinker_unit: errors");
        $finish;
    end

endmodule
